[rtl/core/rss_pkg.sv]
// Shared types and codes for the robot safety supervisor.
// No dependencies; every other file of the block imports this package.
package rss_pkg;

  localparam int unsigned RssQueueDepth = 2;

  localparam int unsigned NumModules = 9;

  // Fault kinds, in the encoding of the fault_kind result field.
  localparam logic [2:0] FaultNone      = 3'd0;
  localparam logic [2:0] FaultLink      = 3'd1;
  localparam logic [2:0] FaultArmState  = 3'd2;
  localparam logic [2:0] FaultBadStatus = 3'd3;
  localparam logic [2:0] FaultNoCmd     = 3'd4;
  localparam logic [2:0] FaultBadCmd    = 3'd5;
  localparam logic [2:0] FaultPktLost   = 3'd6;

  // Supervisor request codes carried by a command.
  localparam logic [1:0] ReqEnableHw   = 2'd1;
  localparam logic [1:0] ReqEnableCtrl = 2'd2;

  // Output modes.
  localparam logic [1:0] ModeSafeValid = 2'd0;
  localparam logic [1:0] ModeSafeAll   = 2'd1;
  localparam logic [1:0] ModePassThru  = 2'd2;

  typedef struct packed {
    logic [8:0]  link_ok_mask;
    logic [1:0]  arm_state_bad_mask;
    logic [8:0]  nan_status_mask;
    logic [7:0]  nan_submodule;
    logic        cmd_received;
    logic        cmd_has_nan;
    logic [3:0]  cmd_bad_module;
    logic [7:0]  cmd_bad_submodule;
    logic [31:0] cmd_sequence;
    logic        sc_request_valid;
    logic [1:0]  sc_request;
    logic [1:0]  arm_monitor_mask;
  } in_data_t;

  typedef struct packed {
    logic [1:0]  state_code;
    logic        fault_flag;
    logic [2:0]  fault_kind;
    logic [3:0]  fault_module;
    logic [7:0]  fault_submodule;
    logic [31:0] tick_count;
    logic        hardware_ok;
    logic [1:0]  output_mode;
    logic [4:0]  safe_device_mask;
    logic [1:0]  arm_start_mask;
  } out_data_t;

  typedef struct packed {
    logic       flag;
    logic [2:0] kind;
    logic [3:0] module_id;
    logic [7:0] submodule;
  } fault_t;

  // One classified tick, as handed from the front end to the back end.
  typedef struct packed {
    fault_t      hw_fault;
    logic        all_ok;
    logic [4:0]  safe_mask;
    logic        cmd_received;
    logic        cmd_has_nan;
    logic [3:0]  cmd_bad_module;
    logic [7:0]  cmd_bad_submodule;
    logic [31:0] cmd_sequence;
    logic        held_valid;
    logic [1:0]  held_request;
    logic [1:0]  monitor_mask;
  } entry_t;

endpackage

[rtl/core/rss_if.sv]
// Valid/ready channel interfaces for the input ticks and the results.
// Depends on rss_pkg for the payload types.
interface rss_in_if;
  import rss_pkg::*;
  logic     valid;
  logic     ready;
  in_data_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rss_out_if;
  import rss_pkg::*;
  logic      valid;
  logic      ready;
  out_data_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/rss_front.sv]
// Front end: accepts ticks, merges arm links with the previous tick, encodes
// the first module fault and tracks the held supervisor request. Uses rss_pkg.
module rss_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  rss_in_if.sink          in_i,
  input  logic            q_ready_i,
  output logic            push_o,
  output rss_pkg::entry_t entry_o
);
  import rss_pkg::*;

  logic [1:0] prev_link_q, prev_link_d;
  logic       held_valid_q, held_valid_d;
  logic [1:0] held_req_q, held_req_d;
  logic [8:0] valid_mask;
  fault_t     fault;
  in_data_t   d;

  assign d        = in_i.data;
  assign in_i.ready = q_ready_i;
  assign push_o   = in_i.valid && q_ready_i;

  always_comb begin
    valid_mask[1:0] = (prev_link_q | d.link_ok_mask[1:0]) & ~d.arm_state_bad_mask
                      & ~d.nan_status_mask[1:0];
    valid_mask[8:2] = d.link_ok_mask[8:2] & ~d.nan_status_mask[8:2];
  end

  // Priority encoder: checks are applied from last to first so that the
  // earliest check in the fixed order wins.
  always_comb begin
    fault = '{flag: 1'b0, kind: FaultNone, module_id: 4'd0, submodule: 8'd0};
    for (int i = NumModules - 1; i >= 2; i--) begin
      if (d.nan_status_mask[i]) begin
        fault = '{flag: 1'b1, kind: FaultBadStatus, module_id: 4'(i + 1),
                  submodule: d.nan_submodule};
      end
      if (!d.link_ok_mask[i]) begin
        fault = '{flag: 1'b1, kind: FaultLink, module_id: 4'(i + 1), submodule: 8'd0};
      end
    end
    for (int i = 1; i >= 0; i--) begin
      if (d.nan_status_mask[i]) begin
        fault = '{flag: 1'b1, kind: FaultBadStatus, module_id: 4'(i + 1),
                  submodule: d.nan_submodule};
      end
    end
    for (int i = 1; i >= 0; i--) begin
      if (d.arm_state_bad_mask[i]) begin
        fault = '{flag: 1'b1, kind: FaultArmState, module_id: 4'(i + 1), submodule: 8'd0};
      end
    end
    for (int i = 1; i >= 0; i--) begin
      if (!(prev_link_q[i] || d.link_ok_mask[i])) begin
        fault = '{flag: 1'b1, kind: FaultLink, module_id: 4'(i + 1), submodule: 8'd0};
      end
    end
  end

  always_comb begin
    prev_link_d  = prev_link_q;
    held_valid_d = held_valid_q;
    held_req_d   = held_req_q;
    if (push_o) begin
      prev_link_d = d.link_ok_mask[1:0];
      if (d.cmd_received) begin
        held_valid_d = d.sc_request_valid;
        held_req_d   = d.sc_request;
      end
    end
  end

  always_comb begin
    entry_o.hw_fault          = fault;
    entry_o.all_ok            = &valid_mask;
    entry_o.safe_mask         = {valid_mask[8:6], valid_mask[1:0]};
    entry_o.cmd_received      = d.cmd_received;
    entry_o.cmd_has_nan       = d.cmd_has_nan;
    entry_o.cmd_bad_module    = d.cmd_bad_module;
    entry_o.cmd_bad_submodule = d.cmd_bad_submodule;
    entry_o.cmd_sequence      = d.cmd_sequence;
    entry_o.held_valid        = held_valid_d;
    entry_o.held_request      = held_req_d;
    entry_o.monitor_mask      = d.arm_monitor_mask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_link_q  <= 2'b11;
      held_valid_q <= 1'b0;
      held_req_q   <= 2'd0;
    end else begin
      prev_link_q  <= prev_link_d;
      held_valid_q <= held_valid_d;
      held_req_q   <= held_req_d;
    end
  end

endmodule

[rtl/core/rss_queue.sv]
// Short FIFO of classified ticks between the front end and the back end.
// Uses rss_pkg for the entry type.
module rss_queue #(
  parameter int unsigned Depth = rss_pkg::RssQueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rss_pkg::entry_t entry_i,
  output logic            ready_o,
  input  logic            pop_i,
  output logic            valid_o,
  output rss_pkg::entry_t entry_o
);
  import rss_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign ready_o = (cnt_q != CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

[rtl/core/rss_back.sv]
// Back end: command checks against the packet counter, the supervisor state
// machine and the result register. Uses rss_pkg and rss_out_if.
module rss_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  rss_pkg::entry_t entry_i,
  output logic            pop_o,
  rss_out_if.source       out_o
);
  import rss_pkg::*;

  typedef enum logic [1:0] {
    StDown     = 2'd0,
    StDisabled = 2'd1,
    StEnabled  = 2'd2,
    StControl  = 2'd3
  } state_e;

  state_e      state_q, state_d;
  logic [31:0] counter_q, counter_d;
  logic        out_valid_q, out_valid_d;
  out_data_t   out_q, out_d;
  fault_t      fault;
  logic        cmd_ok;

  assign pop_o       = q_valid_i && (!out_valid_q || out_o.ready);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_comb begin
    fault  = entry_i.hw_fault;
    cmd_ok = 1'b0;
    if (!entry_i.cmd_received) begin
      if (!fault.flag) begin
        fault = '{flag: 1'b1, kind: FaultNoCmd, module_id: 4'd0, submodule: 8'd0};
      end
    end else if (entry_i.cmd_has_nan) begin
      if (!fault.flag) begin
        fault = '{flag: 1'b1, kind: FaultBadCmd, module_id: entry_i.cmd_bad_module,
                  submodule: entry_i.cmd_bad_submodule};
      end
    end else if (state_q != StDown && entry_i.cmd_sequence != counter_q) begin
      if (!fault.flag) begin
        fault = '{flag: 1'b1, kind: FaultPktLost, module_id: 4'd0, submodule: 8'd0};
      end
    end else begin
      cmd_ok = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StDown: begin
        if (entry_i.all_ok) state_d = StDisabled;
      end
      StDisabled: begin
        if (!entry_i.all_ok) begin
          state_d = StDown;
        end else if (entry_i.held_valid && entry_i.held_request == ReqEnableHw) begin
          state_d = StEnabled;
        end
      end
      StEnabled: begin
        if (!entry_i.all_ok) begin
          state_d = StDown;
        end else if (cmd_ok && entry_i.held_valid
                     && entry_i.held_request == ReqEnableCtrl) begin
          state_d = StControl;
        end
      end
      StControl: begin
        if (!entry_i.all_ok) begin
          state_d = StDown;
        end else if (!cmd_ok) begin
          state_d = StEnabled;
        end
      end
      default: state_d = StDown;
    endcase
  end

  always_comb begin
    out_d                  = out_q;
    out_valid_d            = out_valid_q && !out_o.ready;
    counter_d              = counter_q;
    if (pop_o) begin
      counter_d                  = counter_q + 32'd1;
      out_valid_d                = 1'b1;
      out_d.state_code           = state_d;
      out_d.fault_flag           = fault.flag;
      out_d.fault_kind           = fault.kind;
      out_d.fault_module         = fault.module_id;
      out_d.fault_submodule      = fault.submodule;
      out_d.tick_count           = counter_d;
      out_d.hardware_ok          = entry_i.all_ok;
      out_d.safe_device_mask     = 5'd0;
      out_d.arm_start_mask       = 2'd0;
      case (state_d)
        StDown: begin
          out_d.output_mode      = ModeSafeValid;
          out_d.safe_device_mask = entry_i.safe_mask;
        end
        StControl: out_d.output_mode = ModePassThru;
        default: begin
          out_d.output_mode = ModeSafeAll;
          if (state_d == StEnabled && entry_i.held_valid
              && entry_i.held_request == ReqEnableHw) begin
            out_d.arm_start_mask = entry_i.monitor_mask;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StDown;
      counter_q   <= 32'd1;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= pop_o ? state_d : state_q;
      counter_q   <= counter_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

endmodule

[rtl/core/robot_safety_supervisor_fsm_top.sv]
// Top level of the robot safety supervisor: front end, tick queue, back end.
// Depends on rss_pkg, rss_if, rss_front, rss_queue and rss_back.

// The supervisor takes one tick per clock cycle on in_i while the queue has
// room and delivers one result per tick on out_o, in order, through the queue
// and the back end's result register. The front end merges each arm's link
// flag with the previous tick's, finds the first module fault in the fixed
// check order and keeps the last supervisor request that came with a command.
// The back end checks the command (missing, invalid numbers, or a sequence
// number that differs from the packet counter once the hardware is up),
// steps the four-state supervisor and forms the output mode, the safe-device
// mask and the arm start requests. A short queue of QueueDepth classified
// ticks sits between the two, so the front end keeps accepting ticks while
// a finished result waits on out_o; in_i.ready drops only when that queue
// is full. The sustained rate is one tick per cycle while out_o is not
// stalled, as the back end updates its state for every tick that it pops.
module robot_safety_supervisor_fsm_top #(
  parameter int unsigned QueueDepth = rss_pkg::RssQueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rss_in_if.sink    in_i,
  rss_out_if.source out_o
);
  import rss_pkg::*;

  // Front end to queue.
  logic   push;
  logic   q_ready;
  entry_t front_entry;

  // Queue to back end.
  logic   q_valid;
  logic   pop;
  entry_t back_entry;

  rss_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_ready_i (q_ready),
    .push_o    (push),
    .entry_o   (front_entry)
  );

  rss_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (back_entry)
  );

  rss_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .entry_i   (back_entry),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule

[tb/robot_safety_supervisor_fsm_checker.sv]
// Checker for the robot safety supervisor: predicts each result and compares it.
// Depends on rss_pkg for the payload types and codes, and on rss_if for the channels.
`timescale 1ns / 100ps

module robot_safety_supervisor_fsm_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  rss_in_if           tick_i,
  rss_out_if          result_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned ctrl_ticks_o,
  output int unsigned fault_ticks_o
);
  import rss_pkg::*;

  typedef enum logic [1:0] {HwDown, HwDisabled, HwEnabled, CtrlEnabled} sup_state_e;

  // Shadow copy of the supervisor state.
  sup_state_e  sup_state;
  logic [31:0] pkt_count;
  logic [1:0]  prev_arm_link;
  logic        held_valid;
  logic [1:0]  held_request;

  out_data_t   expected_q[$];

  // Only the first fault of a tick is kept.
  function automatic void note_fault(inout fault_t f, input logic [2:0] kind,
                                     input logic [3:0] module_id,
                                     input logic [7:0] submodule);
    if (!f.flag) begin
      f.flag      = 1'b1;
      f.kind      = kind;
      f.module_id = module_id;
      f.submodule = submodule;
    end
  endfunction

  function automatic out_data_t supervise_tick(input in_data_t t);
    out_data_t  r;
    fault_t     f;
    logic [8:0] ok;
    logic       all_ok;
    logic       cmd_good;
    sup_state_e nxt;
    r        = '0;
    f        = '0;
    cmd_good = 1'b0;
    ok       = '0;

    // An arm link counts as valid if it was seen this tick or the one before.
    ok[1:0]       = prev_arm_link | t.link_ok_mask[1:0];
    prev_arm_link = t.link_ok_mask[1:0];
    for (int i = 0; i < 2; i++)
      if (!ok[i]) note_fault(f, FaultLink, 4'(i + 1), 8'd0);
    for (int i = 0; i < 2; i++)
      if (t.arm_state_bad_mask[i]) begin
        note_fault(f, FaultArmState, 4'(i + 1), 8'd0);
        ok[i] = 1'b0;
      end
    for (int i = 0; i < 2; i++)
      if (t.nan_status_mask[i]) begin
        note_fault(f, FaultBadStatus, 4'(i + 1), t.nan_submodule);
        ok[i] = 1'b0;
      end
    for (int i = 2; i < NumModules; i++) begin
      ok[i] = 1'b1;
      if (!t.link_ok_mask[i]) begin
        note_fault(f, FaultLink, 4'(i + 1), 8'd0);
        ok[i] = 1'b0;
      end
      if (t.nan_status_mask[i]) begin
        note_fault(f, FaultBadStatus, 4'(i + 1), t.nan_submodule);
        ok[i] = 1'b0;
      end
    end
    all_ok = &ok;

    if (t.cmd_received) begin
      held_valid   = t.sc_request_valid;
      held_request = t.sc_request;
    end
    if (!t.cmd_received) note_fault(f, FaultNoCmd, 4'd0, 8'd0);
    else if (t.cmd_has_nan) note_fault(f, FaultBadCmd, t.cmd_bad_module, t.cmd_bad_submodule);
    else if (sup_state != HwDown && t.cmd_sequence != pkt_count)
      note_fault(f, FaultPktLost, 4'd0, 8'd0);
    else cmd_good = 1'b1;

    nxt = sup_state;
    if (sup_state == HwDown) begin
      if (all_ok) nxt = HwDisabled;
    end else if (!all_ok) begin
      nxt = HwDown;
    end else if (sup_state == HwDisabled) begin
      if (held_valid && held_request == ReqEnableHw) nxt = HwEnabled;
    end else if (sup_state == HwEnabled) begin
      if (cmd_good && held_valid && held_request == ReqEnableCtrl) nxt = CtrlEnabled;
    end else begin
      if (!cmd_good) nxt = HwEnabled;
    end
    sup_state = nxt;

    case (nxt)
      HwDown: begin
        r.output_mode      = ModeSafeValid;
        r.safe_device_mask = {ok[8:6], ok[1:0]};
      end
      CtrlEnabled: r.output_mode = ModePassThru;
      default: begin
        r.output_mode = ModeSafeAll;
        if (nxt == HwEnabled && held_valid && held_request == ReqEnableHw)
          r.arm_start_mask = t.arm_monitor_mask;
      end
    endcase

    pkt_count         = pkt_count + 32'd1;
    r.state_code      = nxt;
    r.fault_flag      = f.flag;
    r.fault_kind      = f.kind;
    r.fault_module    = f.module_id;
    r.fault_submodule = f.submodule;
    r.tick_count      = pkt_count;
    r.hardware_ok     = all_ok;
    return r;
  endfunction

  function automatic int unsigned field_diff(input string field, input logic [31:0] want,
                                             input logic [31:0] got);
    int unsigned d;
    d = 0;
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      d = 1;
    end
    return d;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_data_t   want;
    out_data_t   got;
    int unsigned bad;
    if (!rst_ni) begin
      sup_state     = HwDown;
      pkt_count     = 32'd1;
      prev_arm_link = 2'b11;
      held_valid    = 1'b0;
      held_request  = '0;
      expected_q.delete();
      mismatches_o  = 0;
      pending_o     = 0;
      checked_o     = 0;
      ctrl_ticks_o  = 0;
      fault_ticks_o = 0;
    end else begin
      // Results leave only after their tick has passed the queue and the result
      // register, so the result side is handled before this edge's tick is predicted.
      if (result_i.valid && result_i.ready) begin
        got = result_i.data;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual 0x%0h", $time, got);
          mismatches_o++;
        end else begin
          want = expected_q.pop_front();
          bad  = 0;
          bad += field_diff("state_code", 32'(want.state_code), 32'(got.state_code));
          bad += field_diff("fault_flag", 32'(want.fault_flag), 32'(got.fault_flag));
          bad += field_diff("fault_kind", 32'(want.fault_kind), 32'(got.fault_kind));
          bad += field_diff("fault_module", 32'(want.fault_module), 32'(got.fault_module));
          bad += field_diff("fault_submodule", 32'(want.fault_submodule),
                            32'(got.fault_submodule));
          bad += field_diff("tick_count", want.tick_count, got.tick_count);
          bad += field_diff("hardware_ok", 32'(want.hardware_ok), 32'(got.hardware_ok));
          bad += field_diff("output_mode", 32'(want.output_mode), 32'(got.output_mode));
          bad += field_diff("safe_device_mask", 32'(want.safe_device_mask),
                            32'(got.safe_device_mask));
          bad += field_diff("arm_start_mask", 32'(want.arm_start_mask),
                            32'(got.arm_start_mask));
          if (bad != 0) mismatches_o++;
          checked_o++;
          if (want.state_code == CtrlEnabled) ctrl_ticks_o++;
          if (want.fault_flag) fault_ticks_o++;
        end
      end
      if (tick_i.valid && tick_i.ready) expected_q.push_back(supervise_tick(tick_i.data));
      pending_o = expected_q.size();
    end
  end

endmodule

[tb/robot_safety_supervisor_fsm_top_tb.sv]
// Testbench top for the robot safety supervisor: clock, reset, tick stimulus and verdict.
// Depends on rss_pkg, rss_if, the block under test and robot_safety_supervisor_fsm_checker.
`timescale 1ns / 100ps

module robot_safety_supervisor_fsm_top_tb;
  import rss_pkg::*;

  // Request codes that carry no meaning for the supervisor.
  localparam logic [1:0] ReqNone   = 2'd0;
  localparam logic [1:0] ReqUnused = 2'd3;

  localparam int unsigned RandomTicks    = 1700;
  localparam int unsigned HoldAfterTicks = 400;
  localparam int unsigned HoldCycles     = 64;
  localparam int unsigned StallLimit     = 4000;
  localparam int unsigned DrainCycles    = 8;

  typedef enum logic [1:0] {RdyAlways, RdyCoin, RdySparse, RdyToggle} rdy_pattern_e;

  logic        clk_i;
  logic        rst_ni;
  int unsigned ticks_sent = 0;
  int unsigned burst_left = 0;
  logic        hold_active = 1'b0;
  logic        hold_done = 1'b0;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  int unsigned ctrl_ticks;
  int unsigned fault_ticks;

  rss_in_if  in_if ();
  rss_out_if out_if ();

  robot_safety_supervisor_fsm_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // The checker watches both channels on its own; this module only makes the
  // stimulus and reads the counts back at the end.
  robot_safety_supervisor_fsm_checker sup_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_i        (in_if),
    .result_i      (out_if),
    .mismatches_o  (mismatches),
    .pending_o     (pending),
    .checked_o     (checked),
    .ctrl_ticks_o  (ctrl_ticks),
    .fault_ticks_o (fault_ticks)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // A tick with every module healthy and a command whose sequence number
  // matches the packet counter the block will hold when it sees tick n.
  function automatic in_data_t healthy_tick(input int unsigned n);
    in_data_t t;
    t                   = '0;
    t.link_ok_mask      = '1;
    t.nan_submodule     = 8'($urandom);
    t.cmd_received      = 1'b1;
    t.cmd_bad_module    = 4'($urandom);
    t.cmd_bad_submodule = 8'($urandom);
    t.cmd_sequence      = 32'(n) + 32'd1;
    t.sc_request_valid  = 1'b1;
    t.sc_request        = ReqEnableHw;
    t.arm_monitor_mask  = 2'($urandom);
    return t;
  endfunction

  // Most random ticks are healthy with a correct command, so the supervisor
  // climbs to control enabled often; faults are injected now and then and a
  // share of ticks are pure noise.
  function automatic in_data_t random_tick(input int unsigned n);
    in_data_t    t;
    logic [95:0] raw;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      raw = {$urandom, $urandom, $urandom};
      t   = raw[$bits(in_data_t)-1:0];
    end else begin
      t    = healthy_tick(n);
      t.sc_request_valid = ($urandom_range(0, 9) != 0);
      pick = $urandom_range(0, 9);
      if (pick < 4) t.sc_request = ReqEnableHw;
      else if (pick < 8) t.sc_request = ReqEnableCtrl;
      else t.sc_request = 2'($urandom);
      if ($urandom_range(0, 99) < 8) t.link_ok_mask ^= 9'd1 << $urandom_range(0, 8);
      if ($urandom_range(0, 99) < 3) t.arm_state_bad_mask = 2'($urandom_range(1, 3));
      if ($urandom_range(0, 99) < 3) t.nan_status_mask = 9'd1 << $urandom_range(0, 8);
      if ($urandom_range(0, 99) < 6) t.cmd_received = 1'b0;
      if ($urandom_range(0, 99) < 4) t.cmd_has_nan = 1'b1;
      if ($urandom_range(0, 99) < 5) t.cmd_sequence ^= 32'd1 << $urandom_range(0, 31);
    end
    return t;
  endfunction

  // Offers one tick and returns at the falling edge after its transfer. Bursts
  // of random length are separated by random gaps, except while the receiver
  // holds off, when the sender keeps offering so the queue fills up.
  task automatic offer_tick(input in_data_t t);
    int unsigned gap;
    if (burst_left == 0 && !hold_active) begin
      gap = $urandom_range(1, 6);
      in_if.valid <= 1'b0;
      in_if.data  <= in_data_t'($urandom);
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
    end else if (burst_left > 0) begin
      burst_left--;
    end
    in_if.valid <= 1'b1;
    in_if.data  <= t;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  // Receiver: segments of different ready patterns, and one long hold-off
  // once the run is well under way.
  initial begin : receiver
    rdy_pattern_e pat;
    int unsigned  seg_len;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!hold_done && ticks_sent >= HoldAfterTicks) begin
        hold_active = 1'b1;
        for (int c = 0; c < HoldCycles; c++) begin
          @(negedge clk_i);
          out_if.ready <= 1'b0;
        end
        hold_active = 1'b0;
        hold_done   = 1'b1;
      end
      pat     = rdy_pattern_e'($urandom_range(0, 3));
      seg_len = $urandom_range(4, 48);
      for (int c = 0; c < seg_len; c++) begin
        @(negedge clk_i);
        case (pat)
          RdyAlways: out_if.ready <= 1'b1;
          RdyCoin:   out_if.ready <= 1'($urandom_range(0, 1));
          RdySparse: out_if.ready <= ($urandom_range(0, 3) == 0);
          default:   out_if.ready <= c[0];
        endcase
      end
    end
  end

  // Watchdog: ends the run if neither channel makes a transfer for too long.
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle = 0;
      else idle++;
      if (idle >= StallLimit) break;
    end
    $display("%0t: timeout, no transfer for %0d cycles", $time, StallLimit);
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    in_data_t    d;
    int unsigned directed_ticks;
    rst_ni      = 1'b0;
    in_if.valid = 1'b0;
    in_if.data  = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // The sequence number is not checked while the hardware is down.
    d = healthy_tick(ticks_sent);
    d.cmd_sequence = '1;
    d.sc_request   = ReqNone;
    offer_tick(d);
    // Request code 3 means nothing: the supervisor stays disabled.
    d = healthy_tick(ticks_sent);
    d.sc_request = ReqUnused;
    offer_tick(d);
    // No command: fault latched, the held request stays.
    d = healthy_tick(ticks_sent);
    d.cmd_received = 1'b0;
    offer_tick(d);
    // Enable hardware, both arms in monitor mode get a start.
    d = healthy_tick(ticks_sent);
    d.arm_monitor_mask = 2'b11;
    offer_tick(d);
    // No command: the held enable-hardware request still raises the start.
    d = healthy_tick(ticks_sent);
    d.cmd_received     = 1'b0;
    d.arm_monitor_mask = 2'b10;
    offer_tick(d);
    // Enable control.
    d = healthy_tick(ticks_sent);
    d.sc_request = ReqEnableCtrl;
    offer_tick(d);
    // Sequence mismatch drops control back to enabled.
    d = healthy_tick(ticks_sent);
    d.sc_request   = ReqEnableCtrl;
    d.cmd_sequence = d.cmd_sequence + 32'd1;
    offer_tick(d);
    d = healthy_tick(ticks_sent);
    d.sc_request = ReqEnableCtrl;
    offer_tick(d);
    // Command with invalid numbers, extreme module and submodule codes.
    d = healthy_tick(ticks_sent);
    d.cmd_has_nan       = 1'b1;
    d.cmd_bad_module    = '1;
    d.cmd_bad_submodule = '1;
    offer_tick(d);
    // Right arm link missing for one tick is bridged by the previous tick.
    d = healthy_tick(ticks_sent);
    d.link_ok_mask = 9'h1FE;
    offer_tick(d);
    // Missing twice in a row: link fault and the hardware goes down.
    d = healthy_tick(ticks_sent);
    d.link_ok_mask = 9'h1FE;
    offer_tick(d);
    // Everything bad at once.
    d = healthy_tick(ticks_sent);
    d.link_ok_mask       = '0;
    d.arm_state_bad_mask = 2'b11;
    d.nan_status_mask    = '1;
    d.nan_submodule      = '1;
    d.cmd_received       = 1'b0;
    offer_tick(d);
    // Links back, arm states bad.
    d = healthy_tick(ticks_sent);
    d.arm_state_bad_mask = 2'b11;
    offer_tick(d);
    // Bad status on the last module.
    d = healthy_tick(ticks_sent);
    d.nan_status_mask = 9'h100;
    d.nan_submodule   = 8'hA5;
    offer_tick(d);
    // Link lost on the last module.
    d = healthy_tick(ticks_sent);
    d.link_ok_mask = 9'h0FF;
    offer_tick(d);
    d = healthy_tick(ticks_sent);
    offer_tick(d);
    // Request without its valid flag does not enable the hardware.
    d = healthy_tick(ticks_sent);
    d.sc_request_valid = 1'b0;
    offer_tick(d);
    d = healthy_tick(ticks_sent);
    d.arm_monitor_mask = 2'b01;
    offer_tick(d);
    // Bad status on a hand module takes the hardware down from enabled.
    d = healthy_tick(ticks_sent);
    d.nan_status_mask = 9'h004;
    offer_tick(d);
    d = healthy_tick(ticks_sent);
    d.cmd_sequence = '0;
    offer_tick(d);
    directed_ticks = ticks_sent;

    for (int k = 0; k < RandomTicks; k++) offer_tick(random_tick(ticks_sent));
    in_if.valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Run covered %0d ticks (%0d directed) and checked %0d results.",
             ticks_sent, directed_ticks, checked);
    $display("Results in control enabled: %0d; results with a latched fault: %0d.",
             ctrl_ticks, fault_ticks);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
